// ===== rtl/rrpa_pkg.sv =====
// Shared types, codes and helper functions of the round-robin port allocator.
package rrpa_pkg;

  localparam int PORT_W    = 16;
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [PORT_W-1:0] FIRST_RESET = 16'd20000;
  localparam logic [PORT_W-1:0] LAST_RESET  = 16'd21023;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LAST  = 1'b1;

  typedef enum logic [1:0] {
    ST_GRANTED = 2'd0,
    ST_NONE    = 2'd1,
    ST_FREED   = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    logic    clr_wr;
    logic    rd_target;
    logic    wr_set;
    logic    wr_clear;
    logic    mod_init;
    logic    mod_step;
    logic    scan_init;
    logic    scan_rd;
    logic    scan_adv;
    logic    scan_take;
    logic    set_res;
    status_t res_code;
    logic    post;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic is_free;
    logic in_range;
    logic pref_ok;
    logic full;
    logic tgt_busy;
    logic cur_in_span;
    logic mod_last;
    logic hit;
    logic final_word;
    logic out_free;
  } stat_t;

  // position of the lowest set bit (0 when none)
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) pos = BIT_W'(i);
    end
    return pos;
  endfunction

  function automatic logic [WORD_BITS-1:0] ge_mask(input logic [BIT_W-1:0] b);
    return {WORD_BITS{1'b1}} << b;
  endfunction

  function automatic logic [WORD_BITS-1:0] lt_mask(input logic [BIT_W-1:0] b);
    return ~({WORD_BITS{1'b1}} << b);
  endfunction

  function automatic logic [WORD_BITS-1:0] le_mask(input logic [BIT_W-1:0] b);
    return ~(({WORD_BITS{1'b1}} << b) << 1);
  endfunction

  function automatic logic [WORD_BITS-1:0] bit_sel(input logic [BIT_W-1:0] b);
    return WORD_BITS'(1) << b;
  endfunction

endpackage

// ===== rtl/rrpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rrpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rrpa_datapath.sv =====
// Datapath: range registers, busy-map RAM, cursor, remainder unit, word scan, result beat.
module rrpa_datapath #(
  parameter int MAX_PORTS = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [rrpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rrpa_pkg::PORT_W-1:0]         cfg_data,
  input  logic [rrpa_pkg::PORT_W-1:0]         in_data,
  input  logic [1:0]                          in_user,
  input  rrpa_pkg::cmd_t                      cmd,
  output rrpa_pkg::stat_t                     stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rrpa_pkg::PORT_W-1:0]         out_data,
  output logic [1:0]                          out_user
);

  localparam int PW      = rrpa_pkg::PORT_W;
  localparam int WB      = rrpa_pkg::WORD_BITS;
  localparam int BW      = rrpa_pkg::BIT_W;
  localparam int SLOT_W  = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
  localparam int N_W     = SLOT_W + 1;
  localparam int WORDS   = (MAX_PORTS + WB - 1) / WB;
  localparam int WORD_AW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IDX_W   = WORD_AW + BW;
  localparam int ADDR_W  = WORD_AW + 1;
  localparam int DEPTH   = 2 ** ADDR_W;
  localparam int U_W     = $clog2(2 * MAX_PORTS + 1);
  localparam int MB_W    = (SLOT_W > 1) ? $clog2(SLOT_W) : 1;

  // configuration and span size
  logic [PW-1:0]  first, last;
  logic [N_W-1:0] n_reg, n_next;
  logic [PW:0]    span_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      first <= rrpa_pkg::FIRST_RESET;
      last  <= rrpa_pkg::LAST_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        rrpa_pkg::REG_FIRST: first <= cfg_data;
        rrpa_pkg::REG_LAST:  last  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign span_raw = {1'b0, last} - {1'b0, first} + (PW+1)'(1);

  always_comb begin
    if (last < first) n_next = '0;
    else if (span_raw > (PW+1)'(MAX_PORTS)) n_next = N_W'(MAX_PORTS);
    else n_next = N_W'(span_raw);
  end

  always_ff @(posedge clk) n_reg <= n_next;

  // latched request
  logic          op, proto;
  logic [PW-1:0] port;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= in_user[0];
      proto <= in_user[1];
      port  <= in_data;
    end
  end

  // target slot of the request port
  logic [PW-1:0]      off;
  logic [IDX_W-1:0]   tgt_idx;
  logic [WORD_AW-1:0] tgt_word;
  logic [BW-1:0]      tgt_bit;
  logic               in_range;

  assign off      = port - first;
  assign tgt_idx  = off[IDX_W-1:0];
  assign tgt_word = tgt_idx[IDX_W-1:BW];
  assign tgt_bit  = tgt_idx[BW-1:0];
  assign in_range = (port >= first) && ({1'b0, off} < (PW+1)'(n_reg));

  // busy count
  logic [U_W-1:0] used;

  // round-robin cursor and remainder unit for a stale cursor
  logic [SLOT_W-1:0] cursor, cursor_next;
  logic [N_W-1:0]    rem, rem_shift;
  logic [MB_W-1:0]   mcnt;
  logic              cur_in_span;

  assign cur_in_span = N_W'(cursor) < n_reg;
  assign rem_shift   = {rem[N_W-2:0], cursor[mcnt]};

  always_ff @(posedge clk) begin
    if (cmd.mod_init) begin
      rem  <= '0;
      mcnt <= MB_W'(SLOT_W - 1);
    end else if (cmd.mod_step) begin
      rem  <= (rem_shift >= n_reg) ? rem_shift - n_reg : rem_shift;
      mcnt <= mcnt - MB_W'(1);
    end
  end

  // busy-map RAM: one word of slots per address, protocol in the top address bit
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr, clr_addr;
  logic [WB-1:0]     ram_wdata, rdata;

  rrpa_ram #(
    .WIDTH(WB),
    .DEPTH(DEPTH)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  // word scan state
  logic [WORD_AW-1:0] wp, sw;
  logic [BW-1:0]      sb;
  logic               wrapped;
  logic [SLOT_W-1:0]  start_slot;
  logic [IDX_W-1:0]   start_idx, nm1, hit_idx;
  logic [IDX_W:0]     nm1_wide, idx_inc;
  logic [WORD_AW-1:0] last_word;
  logic [BW-1:0]      last_bit, hbit;
  logic [WB-1:0]      hi_mask, lo_mask, cand;
  logic               final_word, hit;

  assign start_slot = cur_in_span ? cursor : rem[SLOT_W-1:0];
  assign start_idx  = IDX_W'(start_slot);
  assign nm1_wide   = (IDX_W+1)'(n_reg) - (IDX_W+1)'(1);
  assign nm1        = nm1_wide[IDX_W-1:0];
  assign last_word  = nm1[IDX_W-1:BW];
  assign last_bit   = nm1[BW-1:0];
  assign final_word = wrapped && (wp == sw);

  always_comb begin
    hi_mask = (wp == last_word) ? rrpa_pkg::le_mask(last_bit) : '1;
    if (final_word) lo_mask = rrpa_pkg::lt_mask(sb);
    else if (!wrapped && wp == sw) lo_mask = rrpa_pkg::ge_mask(sb);
    else lo_mask = '1;
  end

  assign cand    = ~rdata & hi_mask & lo_mask;
  assign hit     = |cand;
  assign hbit    = rrpa_pkg::lowest_set(cand);
  assign hit_idx = {wp, hbit};
  assign idx_inc = (IDX_W+1)'(hit_idx) + (IDX_W+1)'(1);

  assign cursor_next = (idx_inc == (IDX_W+1)'(n_reg)) ? '0 : SLOT_W'(idx_inc);

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      wp      <= start_idx[IDX_W-1:BW];
      sw      <= start_idx[IDX_W-1:BW];
      sb      <= start_idx[BW-1:0];
      wrapped <= 1'b0;
    end else if (cmd.scan_adv) begin
      if (wp == last_word) begin
        wp      <= '0;
        wrapped <= 1'b1;
      end else begin
        wp <= wp + WORD_AW'(1);
      end
    end
  end

  // RAM port selection
  assign ram_we    = cmd.clr_wr | cmd.wr_set | cmd.wr_clear | cmd.scan_take;
  assign ram_waddr = cmd.clr_wr ? clr_addr : {proto, (cmd.scan_take ? wp : tgt_word)};
  assign ram_re    = cmd.rd_target | cmd.scan_rd;
  assign ram_raddr = {proto, (cmd.scan_rd ? wp : tgt_word)};

  always_comb begin
    if (cmd.clr_wr) ram_wdata = '0;
    else if (cmd.wr_clear) ram_wdata = rdata & ~rrpa_pkg::bit_sel(tgt_bit);
    else if (cmd.wr_set) ram_wdata = rdata | rrpa_pkg::bit_sel(tgt_bit);
    else ram_wdata = rdata | rrpa_pkg::bit_sel(hbit);
  end

  // clear sweep, cursor and busy count
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      cursor   <= '0;
      used     <= '0;
    end else begin
      if (cmd.clr_wr) clr_addr <= clr_addr + ADDR_W'(1);
      if (cmd.scan_take) cursor <= cursor_next;
      if (cmd.wr_set || cmd.scan_take) used <= used + U_W'(1);
      else if (cmd.wr_clear && rdata[tgt_bit] && used != '0) used <= used - U_W'(1);
    end
  end

  // result under construction
  logic [PW-1:0]     grant;
  rrpa_pkg::status_t res;

  always_ff @(posedge clk) begin
    if (cmd.load) grant <= '0;
    else if (cmd.wr_set) grant <= port;
    else if (cmd.scan_take) grant <= first + PW'(hit_idx);
    if (cmd.set_res) res <= cmd.res_code;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.post) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      out_data <= grant;
      out_user <= res;
    end
  end

  // status back to the controller
  assign stat.clear_done  = (clr_addr == {ADDR_W{1'b1}});
  assign stat.is_free     = (op == rrpa_pkg::OP_FREE);
  assign stat.in_range    = in_range;
  assign stat.pref_ok     = (port != '0) && in_range;
  assign stat.full        = (N_W+1)'(used) >= {n_reg, 1'b0};
  assign stat.tgt_busy    = rdata[tgt_bit];
  assign stat.cur_in_span = cur_in_span;
  assign stat.mod_last    = (mcnt == '0);
  assign stat.hit         = hit;
  assign stat.final_word  = final_word;
  assign stat.out_free    = !out_valid || out_ready;

endmodule

// ===== rtl/rrpa_ctrl.sv =====
// Controller: sequences clear sweep, request decode, map read-modify-write and word scan.
module rrpa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rrpa_pkg::stat_t stat,
  output rrpa_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_TGT_RD,
    S_TGT_CHK,
    S_MOD,
    S_SCAN_INIT,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_POST
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.res_code = rrpa_pkg::ST_NONE;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.is_free) begin
          if (stat.in_range) begin
            state_next = S_TGT_RD;
          end else begin
            cmd.set_res  = 1'b1;
            cmd.res_code = rrpa_pkg::ST_IGNORED;
            state_next   = S_POST;
          end
        end else if (stat.full) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = rrpa_pkg::ST_NONE;
          state_next   = S_POST;
        end else if (stat.pref_ok) begin
          state_next = S_TGT_RD;
        end else if (stat.cur_in_span) begin
          state_next = S_SCAN_INIT;
        end else begin
          cmd.mod_init = 1'b1;
          state_next   = S_MOD;
        end
      end
      S_TGT_RD: begin
        cmd.rd_target = 1'b1;
        state_next    = S_TGT_CHK;
      end
      S_TGT_CHK: begin
        if (stat.is_free) begin
          cmd.wr_clear = 1'b1;
          cmd.set_res  = 1'b1;
          cmd.res_code = rrpa_pkg::ST_FREED;
          state_next   = S_POST;
        end else if (!stat.tgt_busy) begin
          cmd.wr_set   = 1'b1;
          cmd.set_res  = 1'b1;
          cmd.res_code = rrpa_pkg::ST_GRANTED;
          state_next   = S_POST;
        end else if (stat.cur_in_span) begin
          state_next = S_SCAN_INIT;
        end else begin
          cmd.mod_init = 1'b1;
          state_next   = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) state_next = S_SCAN_INIT;
      end
      S_SCAN_INIT: begin
        cmd.scan_init = 1'b1;
        state_next    = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_next  = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (stat.hit) begin
          cmd.scan_take = 1'b1;
          cmd.set_res   = 1'b1;
          cmd.res_code  = rrpa_pkg::ST_GRANTED;
          state_next    = S_POST;
        end else if (stat.final_word) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = rrpa_pkg::ST_NONE;
          state_next   = S_POST;
        end else begin
          cmd.scan_adv = 1'b1;
          state_next   = S_SCAN_RD;
        end
      end
      S_POST: begin
        if (stat.out_free) begin
          cmd.post   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/round_robin_port_allocator.sv =====
// Top level of the round-robin port allocator: controller, datapath and port checks.
//
//   channel  | direction | handshake             | payload
//   s_axis   | in        | tvalid / tready       | tdata port_number, tuser opcode+protocol
//   m_axis   | out       | tvalid / tready       | tdata granted_port, tuser status
//   cfg      | in        | cfg_valid / cfg_ready | cfg_index register, cfg_data value
//
// One request at a time. A reject (full span, or release out of range) goes from accept
// through decode straight to the result beat; an in-range release or a free preferred port
// adds a read-modify-write of its map word; a search reads one 32-slot map word at a time
// (after a busy preferred port, once that check is done), up to ceil(span/32) + 1 words
// from the single RAM read port, after a remainder step per cursor bit when the cursor
// lies beyond a shrunken span. After reset a clearing sweep writes every map word, with
// s_axis_tready low; cfg writes are taken at any time.
// The result register frees s_axis for the next beat while a result waits on
// m_axis_tready.
module round_robin_port_allocator #(
  parameter int MAX_PORTS = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [15:0]                    s_axis_tdata,  // [15:0] port_number
  input  logic [1:0]                     s_axis_tuser,  // [0] opcode, [1] protocol
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [15:0]                    m_axis_tdata,  // [15:0] granted_port
  output logic [1:0]                     m_axis_tuser,  // [1:0] status
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rrpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);

  rrpa_pkg::cmd_t  cmd;
  rrpa_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  rrpa_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  rrpa_datapath #(
    .MAX_PORTS(MAX_PORTS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (s_axis_tdata),
    .in_user  (s_axis_tuser),
    .cmd      (cmd),
    .stat     (stat),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (m_axis_tdata),
    .out_user (m_axis_tuser)
  );

`ifndef SYNTH
  // one request in flight: ready drops right after an accepted beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a request is in flight");

  // no requests taken while the map clearing sweep runs
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_wr |-> !s_axis_tready)
    else $error("input ready during map clear");

  // only a grant carries a nonzero port
  a_port_only_on_grant: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != rrpa_pkg::ST_GRANTED) |-> (m_axis_tdata == 16'd0))
    else $error("nonzero port on a non-grant result");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the round-robin port allocator: directed table, then random phases.
`timescale 1ns / 1ps

module tb;

  localparam int SLOTS       = 1024;
  localparam int WORK_GOAL   = 1050;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE      = 120;

  localparam logic PROTO_TCP = 1'b0;
  localparam logic PROTO_UDP = 1'b1;

  // one result beat as the block should produce it
  typedef struct packed {
    logic [15:0]       port;
    rrpa_pkg::status_t status;
  } grant_t;

  typedef enum logic {ROW_REQ, ROW_SPAN} row_kind_t;

  // directed row: a request beat, or a new span written while idle
  typedef struct {
    row_kind_t         kind;
    logic              op;
    logic              proto;
    logic [15:0]       port;   // span rows: first port
    logic [15:0]       arg;    // span rows: last port; typed request rows: granted port
    bit                typed;
    rrpa_pkg::status_t want;
  } row_t;

  logic                           clk           = 1'b0;
  logic                           rst           = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [15:0]                    s_axis_tdata  = '0;  // [15:0] port_number
  logic [1:0]                     s_axis_tuser  = '0;  // [0] opcode, [1] protocol
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [15:0]                    m_axis_tdata;        // [15:0] granted_port
  logic [1:0]                     m_axis_tuser;        // [1:0] status
  logic                           cfg_valid     = 1'b0;
  logic                           cfg_ready;
  logic [rrpa_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
  logic [15:0]                    cfg_data      = '0;

  round_robin_port_allocator #(
    .MAX_PORTS(SLOTS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  // allocator shadow state
  bit          slot_busy [2][SLOTS];
  int          busy_count = 0;
  int          rr_cursor  = 0;
  logic [15:0] span_first = rrpa_pkg::FIRST_RESET;
  logic [15:0] span_last  = rrpa_pkg::LAST_RESET;

  grant_t pending_grants[$];
  int     mismatches = 0;
  int     work_items = 0;
  int     burst_left = 0;
  bit     req_up     = 1'b0;

  row_t directed_rows [28] = '{
    '{ROW_REQ,  rrpa_pkg::OP_ALLOC, PROTO_TCP, 16'd0,     16'd20000, 1'b1, rrpa_pkg::ST_GRANTED},
    '{ROW_REQ,  rrpa_pkg::OP_ALLOC, PROTO_UDP, 16'd0,     16'd20001, 1'b1, rrpa_pkg::ST_GRANTED},
    '{ROW_REQ,  rrpa_pkg::OP_ALLOC, PROTO_TCP, 16'd21023, 16'd21023, 1'b1, rrpa_pkg::ST_GRANTED},
    '{ROW_REQ,  rrpa_pkg::OP_ALLOC, PROTO_TCP, 16'd21023, 16'd0,     1'b0, rrpa_pkg::ST_GRANTED},
    '{ROW_REQ,  rrpa_pkg::OP_ALLOC, PROTO_UDP, 16'd19999, 16'd0,     1'b0, rrpa_pkg::ST_GRANTED},
    '{ROW_REQ,  rrpa_pkg::OP_ALLOC, PROTO_UDP, 16'd21024, 16'd0,     1'b0, rrpa_pkg::ST_GRANTED},
    '{ROW_REQ,  rrpa_pkg::OP_ALLOC, PROTO_TCP, 16'd65535, 16'd0,     1'b0, rrpa_pkg::ST_GRANTED},
    '{ROW_REQ,  rrpa_pkg::OP_FREE,  PROTO_TCP, 16'd20000, 16'd0,     1'b1, rrpa_pkg::ST_FREED},
    '{ROW_REQ,  rrpa_pkg::OP_FREE,  PROTO_TCP, 16'd20000, 16'd0,     1'b1, rrpa_pkg::ST_FREED},
    '{ROW_REQ,  rrpa_pkg::OP_FREE,  PROTO_UDP, 16'd0,     16'd0,     1'b1, rrpa_pkg::ST_IGNORED},
    '{ROW_REQ,  rrpa_pkg::OP_FREE,  PROTO_UDP, 16'd65535, 16'd0,     1'b1, rrpa_pkg::ST_IGNORED},
    '{ROW_REQ,  rrpa_pkg::OP_ALLOC, PROTO_TCP, 16'd20000, 16'd20000, 1'b1, rrpa_pkg::ST_GRANTED},
    // one-port span at the top: busy count left from the wide span makes it full
    '{ROW_SPAN, rrpa_pkg::OP_ALLOC, PROTO_TCP, 16'd65535, 16'd65535, 1'b0, rrpa_pkg::ST_GRANTED},
    '{ROW_REQ,  rrpa_pkg::OP_ALLOC, PROTO_TCP, 16'd65535, 16'd0,     1'b1, rrpa_pkg::ST_NONE},
    '{ROW_REQ,  rrpa_pkg::OP_FREE,  PROTO_TCP, 16'd65535, 16'd0,     1'b1, rrpa_pkg::ST_FREED},
    '{ROW_REQ,  rrpa_pkg::OP_FREE,  PROTO_TCP, 16'd1,     16'd0,     1'b1, rrpa_pkg::ST_IGNORED},
    // oversized span, clamped to SLOTS ports
    '{ROW_SPAN, rrpa_pkg::OP_ALLOC, PROTO_TCP, 16'd1,     16'd65535, 1'b0, rrpa_pkg::ST_GRANTED},
    '{ROW_REQ,  rrpa_pkg::OP_ALLOC, PROTO_UDP, 16'd1,     16'd1,     1'b1, rrpa_pkg::ST_GRANTED},
    '{ROW_REQ,  rrpa_pkg::OP_ALLOC, PROTO_UDP, 16'd1024,  16'd1024,  1'b1, rrpa_pkg::ST_GRANTED},
    '{ROW_REQ,  rrpa_pkg::OP_ALLOC, PROTO_TCP, 16'd1025,  16'd0,     1'b0, rrpa_pkg::ST_GRANTED},
    // empty span
    '{ROW_SPAN, rrpa_pkg::OP_ALLOC, PROTO_TCP, 16'd300,   16'd299,   1'b0, rrpa_pkg::ST_GRANTED},
    '{ROW_REQ,  rrpa_pkg::OP_ALLOC, PROTO_TCP, 16'd300,   16'd0,     1'b1, rrpa_pkg::ST_NONE},
    '{ROW_REQ,  rrpa_pkg::OP_FREE,  PROTO_TCP, 16'd300,   16'd0,     1'b1, rrpa_pkg::ST_IGNORED},
    // shrunk span: cursor beyond it, then fill up to full
    '{ROW_SPAN, rrpa_pkg::OP_ALLOC, PROTO_TCP, 16'd20000, 16'd20005, 1'b0, rrpa_pkg::ST_GRANTED},
    '{ROW_REQ,  rrpa_pkg::OP_ALLOC, PROTO_TCP, 16'd0,     16'd0,     1'b0, rrpa_pkg::ST_GRANTED},
    '{ROW_REQ,  rrpa_pkg::OP_ALLOC, PROTO_TCP, 16'd20002, 16'd0,     1'b0, rrpa_pkg::ST_GRANTED},
    '{ROW_REQ,  rrpa_pkg::OP_ALLOC, PROTO_UDP, 16'd0,     16'd0,     1'b0, rrpa_pkg::ST_GRANTED},
    '{ROW_REQ,  rrpa_pkg::OP_ALLOC, PROTO_UDP, 16'd0,     16'd0,     1'b0, rrpa_pkg::ST_GRANTED}
  };

  function automatic int span_size();
    int n;
    if (span_last < span_first) return 0;
    n = int'(span_last) - int'(span_first) + 1;
    return (n > SLOTS) ? SLOTS : n;
  endfunction

  function automatic bit port_in_span(input logic [15:0] port, input int n);
    return int'(port) >= int'(span_first) && int'(port) - int'(span_first) < n;
  endfunction

  // expected grant/status for one request, updating the shadow state
  function automatic grant_t predict_grant(input logic op, input logic proto,
                                           input logic [15:0] port);
    grant_t res;
    int     n;
    int     idx;
    int     start;
    bit     found;
    n = span_size();
    res.port   = '0;
    res.status = rrpa_pkg::ST_NONE;
    found      = 1'b0;
    if (op == rrpa_pkg::OP_FREE) begin
      if (!port_in_span(port, n)) begin
        res.status = rrpa_pkg::ST_IGNORED;
      end else begin
        idx = int'(port) - int'(span_first);
        if (slot_busy[proto][idx] && busy_count > 0) busy_count--;
        slot_busy[proto][idx] = 1'b0;
        res.status = rrpa_pkg::ST_FREED;
      end
    end else if (busy_count < 2 * n) begin
      idx = int'(port) - int'(span_first);
      if (port != 0 && port_in_span(port, n) && !slot_busy[proto][idx]) begin
        found = 1'b1;
      end else begin
        // round-robin search from the shared cursor
        start = rr_cursor % n;
        for (int i = 0; i < n && !found; i++) begin
          idx = (start + i) % n;
          if (!slot_busy[proto][idx]) begin
            found     = 1'b1;
            rr_cursor = (idx + 1) % n;
          end
        end
      end
      if (found) begin
        slot_busy[proto][idx] = 1'b1;
        busy_count++;
        res.port   = 16'(int'(span_first) + idx);
        res.status = rrpa_pkg::ST_GRANTED;
      end
    end
    return res;
  endfunction

  function automatic logic [15:0] pick_busy_port(input logic proto, input int n);
    int start;
    int idx;
    start = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) begin
      idx = (start + i) % n;
      if (slot_busy[proto][idx]) return 16'(int'(span_first) + idx);
    end
    return 16'(int'(span_first) + start);
  endfunction

  // just outside the span, on either side
  function automatic logic [15:0] border_port(input int n);
    return ($urandom_range(0, 1) == 1) ? 16'(int'(span_first) - 1) : 16'(int'(span_first) + n);
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // drive one request beat; predict at acceptance; close bursts with gaps
  task automatic send_request(input logic op, input logic proto, input logic [15:0] port,
                              input bit typed = 1'b0, input logic [15:0] want_port = '0,
                              input rrpa_pkg::status_t want_status = rrpa_pkg::ST_GRANTED);
    grant_t calc;
    int     gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= port;
    s_axis_tuser  <= {proto, op};
    req_up = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    calc = predict_grant(op, proto, port);
    if (typed) begin
      calc.port   = want_port;
      calc.status = want_status;
    end
    pending_grants.push_back(calc);
    work_items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      req_up = 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 12);
    end
  endtask

  // hold off the sender until every result beat is back
  task automatic wait_idle();
    if (req_up) begin
      s_axis_tvalid <= 1'b0;
      req_up = 1'b0;
    end
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  // write both span registers back to back
  task automatic set_span(input logic [15:0] first, input logic [15:0] last);
    cfg_valid <= 1'b1;
    cfg_index <= rrpa_pkg::REG_FIRST;
    cfg_data  <= first;
    do @(posedge clk); while (!cfg_ready);
    span_first = first;
    cfg_index <= rrpa_pkg::REG_LAST;
    cfg_data  <= last;
    do @(posedge clk); while (!cfg_ready);
    span_last = last;
    cfg_valid <= 1'b0;
  endtask

  // full-size span, then release every busy slot of both maps
  task automatic clear_all_slots();
    int base;
    wait_idle();
    base = $urandom_range(1, 65536 - SLOTS);
    set_span(16'(base), 16'(base + SLOTS - 1));
    for (int p = 0; p < 2; p++) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_busy[p][i]) send_request(rrpa_pkg::OP_FREE, p[0], 16'(base + i));
      end
    end
    // a stray release so the sweep always carries a beat
    send_request(rrpa_pkg::OP_FREE, 1'($urandom_range(0, 1)), 16'($urandom));
  endtask

  // result checker
  always @(posedge clk) begin
    grant_t head;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_grants.size() == 0) begin
        report_mismatch("unexpected result beat", m_axis_tdata, 16'd0);
      end else begin
        head = pending_grants.pop_front();
        if (m_axis_tdata !== head.port)
          report_mismatch("granted_port", m_axis_tdata, head.port);
        if (m_axis_tuser !== head.status)
          report_mismatch("status", {14'd0, m_axis_tuser}, {14'd0, head.status});
      end
    end
  end

  // receiver: rotates through always-ready, coin-flip, stall runs and mostly-ready
  logic [31:0] rx_cycle = '0;
  int          rx_hold  = 0;
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_hold != 0) begin
      m_axis_tready <= 1'b0;
      rx_hold       <= rx_hold - 1;
    end else begin
      case (rx_cycle[9:8])
        2'd0: m_axis_tready <= 1'b1;
        2'd1: m_axis_tready <= ($urandom_range(0, 1) == 1);
        2'd2: begin
          m_axis_tready <= 1'b1;
          if ($urandom_range(0, 9) == 0) rx_hold <= $urandom_range(1, 12);
        end
        default: m_axis_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // watchdog: cycles without any beat on any channel
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("round_robin_port_allocator regression: fail");
    $finish;
  end

  // stimulus
  initial begin
    int          n;
    int          first;
    int          last;
    int          count;
    int          pick;
    bit          alloc;
    logic        op;
    logic        proto;
    logic [15:0] port;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_SPAN) begin
        wait_idle();
        set_span(directed_rows[i].port, directed_rows[i].arg);
      end else begin
        send_request(directed_rows[i].op, directed_rows[i].proto, directed_rows[i].port,
                     directed_rows[i].typed, directed_rows[i].arg, directed_rows[i].want);
      end
    end

    clear_all_slots();
    work_items = 0;

    // random phases, each with its own span
    while (work_items < WORK_GOAL) begin
      pick = $urandom_range(0, 9);
      case (pick)
        5: begin
          first = 1;
          last  = $urandom_range(1, 40);
        end
        6: begin
          last  = 65535;
          first = 65535 - $urandom_range(0, 39);
        end
        7: begin
          first = $urandom_range(1, 65536 - SLOTS);
          last  = ($urandom_range(0, 1) == 1) ? first + SLOTS - 1 : 65535;
        end
        8: begin
          n     = $urandom_range(41, 300);
          first = $urandom_range(1, 65536 - n);
          last  = first + n - 1;
        end
        9: begin
          first = $urandom_range(2, 65535);
          last  = $urandom_range(1, first - 1);
        end
        default: begin
          n     = $urandom_range(1, 40);
          first = $urandom_range(1, 65536 - n);
          last  = first + n - 1;
        end
      endcase
      wait_idle();
      set_span(16'(first), 16'(last));
      n     = span_size();
      count = (n == 0) ? $urandom_range(8, 16) : $urandom_range(40, 120);

      for (int k = 0; k < count; k++) begin
        if ($urandom_range(0, 49) == 0) wait_idle();
        proto = 1'($urandom_range(0, 1));
        // fill during the first half of a phase, drain during the second
        alloc = $urandom_range(0, 99) < ((k < count / 2) ? 75 : 35);
        if (alloc) begin
          op = rrpa_pkg::OP_ALLOC;
          case ($urandom_range(0, 9))
            0, 1, 2, 3: port = '0;
            4, 5, 6:
              port = (n > 0) ? 16'(int'(span_first) + $urandom_range(0, n - 1))
                             : 16'($urandom);
            7:       port = border_port(n);
            default: port = 16'($urandom);
          endcase
        end else begin
          op = rrpa_pkg::OP_FREE;
          case ($urandom_range(0, 9))
            7, 8:    port = border_port(n);
            9:       port = 16'($urandom);
            default: port = (n > 0) ? pick_busy_port(proto, n) : 16'($urandom);
          endcase
        end
        send_request(op, proto, port);
      end

      // now and then leave busy slots behind for the next span
      if ($urandom_range(0, 2) != 0) clear_all_slots();
    end

    wait_idle();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && pending_grants.size() == 0)
      $display("round_robin_port_allocator regression: pass");
    else
      $display("round_robin_port_allocator regression: fail");
    $finish;
  end

endmodule
